[hdl/aabb_overlap_box_table_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the box table
// Immediate-cycle and next-cycle implications, clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef AABB_OVERLAP_BOX_TABLE_ASSERT_SVH
`define AABB_OVERLAP_BOX_TABLE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define AABB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define AABB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/aabb_pkg.sv]
// ----------------------------------------------------------------------------
// aabb_pkg
// Shared widths, command codes and record types of the box table.
// ----------------------------------------------------------------------------
package aabb_pkg;

  localparam int ID_W      = 9;
  localparam int CAT_W     = 4;
  localparam int POS_W     = 16;
  localparam int SIZE_W    = 15;
  localparam int MASK_W    = 9;
  localparam int SUM_W     = POS_W + 1;
  localparam int CAT_LIMIT = 8;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  // One strict inequality of the overlap test per cell.
  typedef enum logic [1:0] {
    CHK_X_LO = 2'd0,  // qx < bx + bw
    CHK_X_HI = 2'd1,  // bx < qx + qw
    CHK_Y_LO = 2'd2,  // qy < by + bh
    CHK_Y_HI = 2'd3   // by < qy + qh
  } check_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic [SIZE_W-1:0]       w;
    logic [SIZE_W-1:0]       h;
  } query_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic [SIZE_W-1:0]       w;
    logic [SIZE_W-1:0]       h;
    logic [CAT_W-1:0]        cat;
  } box_t;

  typedef struct packed {
    logic vld;
    logic ok;
    box_t box;
  } cell_t;

endpackage

[hdl/aabb_in_if.sv]
// ----------------------------------------------------------------------------
// aabb_in_if
// Command channel of the box table: valid/ready plus one command item.
// ----------------------------------------------------------------------------
interface aabb_in_if import aabb_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [1:0]              cmd;
  logic [ID_W-1:0]         box_id;
  logic [CAT_W-1:0]        category;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic [SIZE_W-1:0]       size_w;
  logic [SIZE_W-1:0]       size_h;
  logic [MASK_W-1:0]       query_mask;

  modport source (
    output valid, cmd, box_id, category, pos_x, pos_y, size_w, size_h, query_mask,
    input  ready
  );
  modport sink (
    input  valid, cmd, box_id, category, pos_x, pos_y, size_w, size_h, query_mask,
    output ready
  );
endinterface

[hdl/aabb_out_if.sv]
// ----------------------------------------------------------------------------
// aabb_out_if
// Result channel of the box table: valid/ready plus one result item.
// ----------------------------------------------------------------------------
interface aabb_out_if import aabb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             hit;
  logic [ID_W-1:0]  hit_slot;
  logic [CAT_W-1:0] hit_category;

  modport source (output valid, hit, hit_slot, hit_category, input ready);
  modport sink   (input  valid, hit, hit_slot, hit_category, output ready);
endinterface

[hdl/aabb_cell.sv]
// ----------------------------------------------------------------------------
// aabb_cell
// One stage of the compare chain: checks one strict inequality of the
// overlap test and hands the candidate box on to its neighbor.
// ----------------------------------------------------------------------------
module aabb_cell import aabb_pkg::*; #(
  parameter check_t CHECK  = CHK_X_LO,
  parameter int     SLOT_W = 9
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              kill,
  input  query_t            q,
  input  cell_t             cell_in,
  input  logic [SLOT_W-1:0] slot_in,
  output cell_t             cell_out,
  output logic [SLOT_W-1:0] slot_out
);

  logic signed [SUM_W-1:0] lhs_s;
  logic signed [SUM_W-1:0] base_s;
  logic signed [SUM_W-1:0] add_s;
  logic signed [SUM_W-1:0] sum_s;
  logic                    pass;
  logic                    vld_r;
  logic                    ok_r;
  box_t                    box_r;
  logic [SLOT_W-1:0]       slot_r;

  always_comb begin
    unique case (CHECK)
      CHK_X_LO: begin
        lhs_s  = SUM_W'(q.x);
        base_s = SUM_W'(cell_in.box.x);
        add_s  = SUM_W'(cell_in.box.w);
      end
      CHK_X_HI: begin
        lhs_s  = SUM_W'(cell_in.box.x);
        base_s = SUM_W'(q.x);
        add_s  = SUM_W'(q.w);
      end
      CHK_Y_LO: begin
        lhs_s  = SUM_W'(q.y);
        base_s = SUM_W'(cell_in.box.y);
        add_s  = SUM_W'(cell_in.box.h);
      end
      CHK_Y_HI: begin
        lhs_s  = SUM_W'(cell_in.box.y);
        base_s = SUM_W'(q.y);
        add_s  = SUM_W'(q.h);
      end
    endcase
    sum_s = base_s + add_s;
    pass  = lhs_s < sum_s;
  end

  // Valid clears on kill; payload just follows.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= cell_in.vld && !kill;
    end
  end

  always_ff @(posedge clk) begin
    ok_r   <= cell_in.ok && pass;
    box_r  <= cell_in.box;
    slot_r <= slot_in;
  end

  assign cell_out.vld = vld_r;
  assign cell_out.ok  = ok_r;
  assign cell_out.box = box_r;
  assign slot_out     = slot_r;

endmodule

[hdl/aabb_overlap_box_table.sv]
// Flow: insert and remove go from S_IDLE through S_DONE into the output register;
// a query reads one table entry per cycle into 4 compare cells until the first hit or
// the table end, then goes to S_DONE. Clear sweeps the table, then replies via S_DONE.
// Throughput: one item at a time; ready is high only in S_IDLE, after the last result
// is loaded into the output register. Reset: synchronous, active low; then a clearing
// pass over the table runs with in_ch.ready low before the first item is taken.
// ----------------------------------------------------------------------------
// aabb_overlap_box_table
// Table of axis-aligned boxes with insert, remove, clear and overlap query.
// ----------------------------------------------------------------------------
`include "aabb_overlap_box_table_assert.svh"

module aabb_overlap_box_table import aabb_pkg::*; #(
  parameter int MAX_BOXES  = 512,
  parameter int COORD_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  aabb_in_if.sink     in_ch,
  aabb_out_if.source  out_ch
);

  localparam int IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CNT_W = $clog2(MAX_BOXES + 1);
  // Coordinates keep at most POS_W bits and are sign-extended from there.
  localparam int CW    = (COORD_BITS < POS_W) ? COORD_BITS : POS_W;
  localparam int CMP_W = (IDX_W > ID_W) ? IDX_W : ID_W;
  localparam int NCELL = 4;

  // Table word: the valid bit lives with the box, so remove and the
  // clearing pass are plain writes.
  typedef struct packed {
    logic              vld;
    logic [CAT_W-1:0]  cat;
    logic [CW-1:0]     x;
    logic [CW-1:0]     y;
    logic [SIZE_W-1:0] w;
    logic [SIZE_W-1:0] h;
  } entry_t;

  typedef enum logic [1:0] {
    S_SWEEP,
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  state_t             state_r;
  logic [CNT_W-1:0]   scan_r;
  logic               sweep_reply_r;
  logic               rd_vld_r;

  query_t             q_r;
  logic [MASK_W-1:0]  qmask_r;
  logic [ID_W-1:0]    qid_r;

  logic               res_hit_r;
  logic [ID_W-1:0]    res_slot_r;
  logic [CAT_W-1:0]   res_cat_r;

  logic               out_vld_r;
  logic               out_hit_r;
  logic [ID_W-1:0]    out_slot_r;
  logic [CAT_W-1:0]   out_cat_r;

  entry_t             mem [MAX_BOXES];
  entry_t             rd_data_r;
  logic [IDX_W-1:0]   rd_slot_r;
  logic [IDX_W-1:0]   rd_addr;

  logic               mem_we;
  logic [IDX_W-1:0]   mem_wa;
  entry_t             mem_wd;
  entry_t             ins_word;

  cmd_t               in_cmd;
  logic               in_acc;
  logic               id_ok;

  cell_t              chain      [NCELL+1];
  logic [IDX_W-1:0]   slot_chain [NCELL+1];
  logic               pipe_busy;
  logic               hit_now;

  // --------------------------------------------------------------------------
  // Handshake
  // --------------------------------------------------------------------------
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_cmd      = cmd_t'(in_ch.cmd);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign id_ok       = int'(in_ch.box_id) < MAX_BOXES;

  assign out_ch.valid        = out_vld_r;
  assign out_ch.hit          = out_hit_r;
  assign out_ch.hit_slot     = out_slot_r;
  assign out_ch.hit_category = out_cat_r;

  // --------------------------------------------------------------------------
  // Table memory: one write port, one registered read port
  // --------------------------------------------------------------------------
  always_comb begin
    ins_word.vld = (in_cmd == CMD_INSERT);
    // Categories beyond the last defined tag fold to "other".
    ins_word.cat = (int'(in_ch.category) > CAT_LIMIT) ? '0 : in_ch.category;
    ins_word.x   = in_ch.pos_x[CW-1:0];
    ins_word.y   = in_ch.pos_y[CW-1:0];
    ins_word.w   = in_ch.size_w;
    ins_word.h   = in_ch.size_h;
  end

  always_comb begin
    if (state_r == S_SWEEP) begin
      mem_we = 1'b1;
      mem_wa = scan_r[IDX_W-1:0];
      mem_wd = '0;
    end else begin
      mem_we = in_acc && id_ok && (in_cmd == CMD_INSERT || in_cmd == CMD_REMOVE);
      mem_wa = IDX_W'(in_ch.box_id);
      mem_wd = ins_word;
    end
  end

  assign rd_addr = scan_r[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[rd_addr];
    rd_slot_r <= rd_addr;
  end

  // --------------------------------------------------------------------------
  // Compare chain. The head filters on valid, own slot and category mask;
  // each cell then checks one inequality. Items leave in slot order, so the
  // first hit out of the tail is the lowest slot.
  // --------------------------------------------------------------------------
  always_comb begin
    chain[0].vld     = rd_vld_r;
    chain[0].ok      = rd_data_r.vld
                       && (CMP_W'(rd_slot_r) != CMP_W'(qid_r))
                       && qmask_r[rd_data_r.cat];
    chain[0].box.x   = POS_W'(signed'(rd_data_r.x));
    chain[0].box.y   = POS_W'(signed'(rd_data_r.y));
    chain[0].box.w   = rd_data_r.w;
    chain[0].box.h   = rd_data_r.h;
    chain[0].box.cat = rd_data_r.cat;
    slot_chain[0]    = rd_slot_r;
  end

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    aabb_cell #(
      .CHECK  (check_t'(k)),
      .SLOT_W (IDX_W)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .kill     (hit_now),
      .q        (q_r),
      .cell_in  (chain[k]),
      .slot_in  (slot_chain[k]),
      .cell_out (chain[k+1]),
      .slot_out (slot_chain[k+1])
    );
  end

  always_comb begin
    pipe_busy = rd_vld_r;
    for (int k = 1; k <= NCELL; k++) begin
      pipe_busy = pipe_busy | chain[k].vld;
    end
  end

  // First hit ends the scan; drop whatever is still in flight behind it.
  assign hit_now = (state_r == S_SCAN) && chain[NCELL].vld && chain[NCELL].ok;

  // --------------------------------------------------------------------------
  // Control: sweep, accept, scan, deliver
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_SWEEP;
      scan_r        <= '0;
      sweep_reply_r <= 1'b0;
      rd_vld_r      <= 1'b0;
      out_vld_r     <= 1'b0;
    end else begin
      // Free the output register once taken; S_DONE refills it on its own.
      if (out_vld_r && out_ch.ready && state_r != S_DONE) begin
        out_vld_r <= 1'b0;
      end

      unique case (state_r)
        S_SWEEP: begin
          if (scan_r == CNT_W'(MAX_BOXES - 1)) begin
            // Reply only when a clear command started the pass.
            scan_r        <= '0;
            sweep_reply_r <= 1'b0;
            state_r       <= sweep_reply_r ? S_DONE : S_IDLE;
          end else begin
            scan_r <= scan_r + 1'b1;
          end
        end

        S_IDLE: begin
          if (in_acc) begin
            res_hit_r  <= 1'b0;
            res_slot_r <= '0;
            res_cat_r  <= '0;
            q_r.x      <= POS_W'(signed'(in_ch.pos_x[CW-1:0]));
            q_r.y      <= POS_W'(signed'(in_ch.pos_y[CW-1:0]));
            q_r.w      <= in_ch.size_w;
            q_r.h      <= in_ch.size_h;
            qmask_r    <= in_ch.query_mask;
            qid_r      <= in_ch.box_id;
            unique case (in_cmd)
              CMD_QUERY: begin
                scan_r  <= '0;
                state_r <= S_SCAN;
              end
              CMD_CLEAR: begin
                scan_r        <= '0;
                sweep_reply_r <= 1'b1;
                state_r       <= S_SWEEP;
              end
              CMD_INSERT, CMD_REMOVE: begin
                state_r <= S_DONE;
              end
            endcase
          end
        end

        S_SCAN: begin
          if (hit_now) begin
            rd_vld_r   <= 1'b0;
            res_hit_r  <= 1'b1;
            res_slot_r <= ID_W'(slot_chain[NCELL]);
            res_cat_r  <= chain[NCELL].box.cat;
            state_r    <= S_DONE;
          end else if (scan_r < CNT_W'(MAX_BOXES)) begin
            rd_vld_r <= 1'b1;
            scan_r   <= scan_r + 1'b1;
          end else begin
            rd_vld_r <= 1'b0;
            if (!pipe_busy) begin
              state_r <= S_DONE;
            end
          end
        end

        S_DONE: begin
          // Hold the result until the output register is free.
          if (!out_vld_r || out_ch.ready) begin
            out_vld_r  <= 1'b1;
            out_hit_r  <= res_hit_r;
            out_slot_r <= res_slot_r;
            out_cat_r  <= res_cat_r;
            state_r    <= S_IDLE;
          end
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `AABB_ASSERT_NOW(a_miss_is_zero, out_vld_r && !out_hit_r,
                   out_slot_r == '0 && out_cat_r == '0, "miss result carries nonzero fields")
  `AABB_ASSERT_NOW(a_ready_pipe_empty, in_ch.ready, !pipe_busy,
                   "item taken while the compare chain is busy")
  `AABB_ASSERT_NOW(a_tail_only_in_scan, chain[NCELL].vld, state_r == S_SCAN,
                   "compare chain active outside a scan")
  `AABB_ASSERT_NEXT(a_query_starts_scan, in_acc && in_cmd == CMD_QUERY,
                    state_r == S_SCAN && scan_r == '0, "query did not start a scan")
  `AABB_ASSERT_NOW(a_scan_bound, state_r == S_SCAN, scan_r <= CNT_W'(MAX_BOXES),
                   "scan counter ran past the table")

endmodule

[tb/sv/aabb_overlap_box_table_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_overlap_box_table_tb
// Sends insert, remove, clear and overlap-query commands to the box table.
// A scoreboard keeps its own copy of the table, works out the result of every
// accepted command, and compares each returned result with the oldest one.
// ----------------------------------------------------------------------------
module aabb_overlap_box_table_tb import aabb_pkg::*; ();

  localparam int BOX_SLOTS     = 512;
  localparam int LONG_STALL    = 600;
  localparam int CYCLE_LIMIT   = 4_000_000;
  localparam int PHASE_ITEMS   = 275;
  localparam logic [MASK_W-1:0] ALL_CATS = '1;

  // One command item as it crosses the input channel.
  typedef struct {
    cmd_t                    op;
    logic [ID_W-1:0]         box_id;
    logic [CAT_W-1:0]        category;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [SIZE_W-1:0]       size_w;
    logic [SIZE_W-1:0]       size_h;
    logic [MASK_W-1:0]       query_mask;
  } box_cmd_t;

  // One result item as it leaves the block.
  typedef struct {
    logic             hit;
    logic [ID_W-1:0]  slot;
    logic [CAT_W-1:0] cat;
  } box_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: mirror of the box table plus the queue of expected results.
  // --------------------------------------------------------------------------
  class box_table_scoreboard;
    bit               slot_valid [BOX_SLOTS];
    logic [CAT_W-1:0] slot_cat   [BOX_SLOTS];
    int               slot_x     [BOX_SLOTS];
    int               slot_y     [BOX_SLOTS];
    int               slot_w     [BOX_SLOTS];
    int               slot_h     [BOX_SLOTS];
    box_result_t      pending_results [$];
    int mismatches;
    int inserts;
    int removes;
    int clears;
    int queries;
    int hits;

    function new();
      mismatches = 0;
      inserts    = 0;
      removes    = 0;
      clears     = 0;
      queries    = 0;
      hits       = 0;
    endfunction

    task report_mismatch(string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatches++;
    endtask

    // Apply an accepted command to the mirror and queue its result.
    function void note_command(box_cmd_t c);
      box_result_t      r;
      logic [CAT_W-1:0] tag;
      int               qx, qy, qw, qh;
      bit               found;
      r.hit  = 1'b0;
      r.slot = '0;
      r.cat  = '0;
      tag    = (c.category > CAT_LIMIT) ? '0 : c.category;
      qx     = c.pos_x;
      qy     = c.pos_y;
      qw     = c.size_w;
      qh     = c.size_h;
      found  = 1'b0;
      case (c.op)
        CMD_INSERT: begin
          inserts++;
          slot_valid[c.box_id] = 1'b1;
          slot_cat[c.box_id]   = tag;
          slot_x[c.box_id]     = qx;
          slot_y[c.box_id]     = qy;
          slot_w[c.box_id]     = qw;
          slot_h[c.box_id]     = qh;
        end
        CMD_REMOVE: begin
          removes++;
          slot_valid[c.box_id] = 1'b0;
        end
        CMD_CLEAR: begin
          clears++;
          foreach (slot_valid[i]) slot_valid[i] = 1'b0;
        end
        default: begin
          queries++;
          for (int i = 0; i < BOX_SLOTS && !found; i++) begin
            if (slot_valid[i] && i != c.box_id && c.query_mask[slot_cat[i]] &&
                qx < slot_x[i] + slot_w[i] && qx + qw > slot_x[i] &&
                qy < slot_y[i] + slot_h[i] && qy + qh > slot_y[i]) begin
              found  = 1'b1;
              r.hit  = 1'b1;
              r.slot = ID_W'(i);
              r.cat  = slot_cat[i];
            end
          end
          if (found) hits++;
        end
      endcase
      pending_results = {pending_results, r};
    endfunction

    task check_result(logic hit, logic [ID_W-1:0] slot, logic [CAT_W-1:0] cat);
      box_result_t want;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result hit=%b slot=%0d cat=%0d with nothing pending",
                                  hit, slot, cat));
      end else begin
        want = pending_results.pop_front();
        if (hit !== want.hit)
          report_mismatch($sformatf("hit %b, expected %b", hit, want.hit));
        if (slot !== want.slot)
          report_mismatch($sformatf("hit_slot %0d, expected %0d", slot, want.slot));
        if (cat !== want.cat)
          report_mismatch($sformatf("hit_category %0d, expected %0d", cat, want.cat));
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  aabb_in_if  in_ch ();
  aabb_out_if out_ch ();

  aabb_overlap_box_table uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  box_table_scoreboard sb;

  // Idle mix in percent; changed by the stimulus between phases.
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;

  // Long receiver hold-off: the stimulus bumps the request count, the
  // receiver process below notices and counts the stall out by itself.
  int stall_requests = 0;
  int stall_seen     = 0;
  int stall_left     = 0;
  int cycle_count    = 0;

  // Receiver: random ready, or a long hold-off when one was requested.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (stall_seen != stall_requests) begin
      stall_seen   <= stall_requests;
      stall_left   <= LONG_STALL;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Sample results mid-cycle: what is valid and ready here is taken at the
  // next rising edge, and nothing changes in between.
  always @(negedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
      sb.check_result(out_ch.hit, out_ch.hit_slot, out_ch.hit_category);
  end

  // Watchdog: a query scans the whole table, so allow plenty of slack.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("** aabb_overlap_box_table: FAILED **");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic box_cmd_t make_cmd(cmd_t op, int id, int cat, int x, int y,
                                        int w, int h, logic [MASK_W-1:0] mask);
    box_cmd_t c;
    c.op         = op;
    c.box_id     = ID_W'(id);
    c.category   = CAT_W'(cat);
    c.pos_x      = POS_W'(x);
    c.pos_y      = POS_W'(y);
    c.size_w     = SIZE_W'(w);
    c.size_h     = SIZE_W'(h);
    c.query_mask = mask;
    return c;
  endfunction

  // Mostly a small window so boxes pile up and overlap; now and then anywhere.
  function automatic int pick_coord();
    if ($urandom_range(9) < 2) return int'($urandom_range(65535)) - 32768;
    return int'($urandom_range(400)) - 200;
  endfunction

  function automatic int pick_size();
    if ($urandom_range(9) < 2) return int'($urandom_range(32767));
    return int'($urandom_range(120));
  endfunction

  // A small pool of slots gives overwrites, removes of live boxes and
  // self-skips; the full range keeps every id bit moving.
  function automatic int pick_slot();
    if ($urandom_range(3) != 0) return int'($urandom_range(47));
    return int'($urandom_range(511));
  endfunction

  function automatic box_cmd_t random_command();
    int   r;
    cmd_t op;
    int   cat;
    logic [MASK_W-1:0] mask;
    r = $urandom_range(99);
    if (r < 42)      op = CMD_INSERT;
    else if (r < 52) op = CMD_REMOVE;
    else if (r < 97) op = CMD_QUERY;
    else             op = CMD_CLEAR;
    // Out-of-range tags fold to "other"; keep them in the mix.
    cat  = ($urandom_range(4) == 0) ? $urandom_range(15) : $urandom_range(CAT_LIMIT);
    mask = ($urandom_range(9) < 6) ? ALL_CATS : MASK_W'($urandom_range(511));
    return make_cmd(op, pick_slot(), cat, pick_coord(), pick_coord(),
                    pick_size(), pick_size(), mask);
  endfunction

  // Offer one item, hold it until the block takes it, then log it.
  task automatic send_command(box_cmd_t c);
    logic took;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.cmd        <= c.op;
    in_ch.box_id     <= c.box_id;
    in_ch.category   <= c.category;
    in_ch.pos_x      <= c.pos_x;
    in_ch.pos_y      <= c.pos_y;
    in_ch.size_w     <= c.size_w;
    in_ch.size_h     <= c.size_h;
    in_ch.query_mask <= c.query_mask;
    do begin
      @(negedge clk);
      took = (in_ch.ready === 1'b1);
      if (!took) @(posedge clk);
    end while (!took);
    @(posedge clk);
    sb.note_command(c);
  endtask

  // Drop valid and wait for every expected result to come back.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending_results.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    box_cmd_t plan [$];
    int       tx_mix [3];
    int       rx_mix [3];
    tx_mix = '{29, 69, 0};
    rx_mix = '{69, 29, 0};
    sb = new();

    in_ch.valid      <= 1'b0;
    in_ch.cmd        <= CMD_INSERT;
    in_ch.box_id     <= '0;
    in_ch.category   <= '0;
    in_ch.pos_x      <= '0;
    in_ch.pos_y      <= '0;
    in_ch.size_w     <= '0;
    in_ch.size_h     <= '0;
    in_ch.query_mask <= '0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. The block clears its table after reset, so the first
    // item waits on ready like any other.
    // Query on an empty table: no hit.
    plan = {plan, make_cmd(CMD_QUERY, 0, 0, 0, 0, 10, 10, ALL_CATS)};
    plan = {plan, make_cmd(CMD_INSERT, 0, 1, 0, 0, 10, 10, '0)};
    // Most negative corner, largest size, top slot, top category.
    plan = {plan, make_cmd(CMD_INSERT, 511, 8, -32768, -32768, 32767, 32767, '0)};
    // Tag above eight is stored as "other".
    plan = {plan, make_cmd(CMD_INSERT, 7, 12, 100, 100, 5, 5, '0)};
    // Zero-width box lying strictly inside slot 0.
    plan = {plan, make_cmd(CMD_INSERT, 3, 4, 4, 2, 0, 4, '0)};
    // Querier owns slot 0, so slot 0 is skipped and the thin box is found.
    plan = {plan, make_cmd(CMD_QUERY, 0, 0, 0, 0, 10, 10, ALL_CATS)};
    // Edges that only touch do not overlap.
    plan = {plan, make_cmd(CMD_QUERY, 9, 0, 10, 0, 5, 5, ALL_CATS)};
    // Mask with only gold, then mask with every category but gold.
    plan = {plan, make_cmd(CMD_QUERY, 9, 0, 9, 9, 1, 1, 9'h002)};
    plan = {plan, make_cmd(CMD_QUERY, 9, 0, 9, 9, 1, 1, 9'h1FD)};
    plan = {plan, make_cmd(CMD_QUERY, 511, 0, -5, -5, 3, 3, ALL_CATS)};
    plan = {plan, make_cmd(CMD_QUERY, 0, 0, -5, -5, 3, 3, ALL_CATS)};
    // Zero-size query point inside the folded-category box, mask "other" only.
    plan = {plan, make_cmd(CMD_QUERY, 1, 0, 102, 102, 0, 0, 9'h001)};
    // Most positive corner with the largest size: sums go past 16 bits.
    plan = {plan, make_cmd(CMD_INSERT, 200, 15, 32767, 32767, 32767, 32767, '0)};
    plan = {plan, make_cmd(CMD_QUERY, 1, 0, 32766, 32766, 32767, 32767, ALL_CATS)};
    // Empty mask never hits.
    plan = {plan, make_cmd(CMD_QUERY, 1, 15, 32767, 32767, 0, 0, '0)};
    // Overwrite a live slot.
    plan = {plan, make_cmd(CMD_INSERT, 0, 6, 50, 50, 1, 1, '0)};
    plan = {plan, make_cmd(CMD_QUERY, 2, 0, 0, 0, 10, 10, ALL_CATS)};
    plan = {plan, make_cmd(CMD_REMOVE, 3, 0, 0, 0, 0, 0, '0)};
    // Remove of a slot that was never filled.
    plan = {plan, make_cmd(CMD_REMOVE, 4, 0, 0, 0, 0, 0, '0)};
    plan = {plan, make_cmd(CMD_QUERY, 2, 0, 0, 0, 60, 60, ALL_CATS)};
    plan = {plan, make_cmd(CMD_CLEAR, 0, 0, 0, 0, 0, 0, '0)};
    plan = {plan, make_cmd(CMD_QUERY, 2, 0, -32768, -32768, 32767, 32767, ALL_CATS)};
    plan = {plan, make_cmd(CMD_INSERT, 1, 2, -1, -1, 2, 2, '0)};
    plan = {plan, make_cmd(CMD_QUERY, 511, 0, 0, 0, 0, 0, ALL_CATS)};
    foreach (plan[i]) send_command(plan[i]);
    drain_results();

    // Random part in three idle mixes: sender light / receiver heavy,
    // the reverse, then both flat out.
    for (int p = 0; p < 3; p++) begin
      tx_idle_pct = tx_mix[p];
      rx_idle_pct = rx_mix[p];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_command(random_command());
        // Starve the output for a long stretch while items keep coming.
        if (p == 0 && n == 40) stall_requests++;
        // Hold the input until the block has answered everything.
        if (n == 150) drain_results();
      end
      drain_results();
    end

    // Let any stray result show up before the verdict.
    repeat (40) @(posedge clk);
    if (sb.pending_results.size() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.pending_results.size()));

    $display("Covered %0d inserts, %0d removes, %0d clears, %0d queries (%0d hits)",
             sb.inserts, sb.removes, sb.clears, sb.queries, sb.hits);
    $display("under three idle mixes, a long result stall and drained pauses; %0d mismatches",
             sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("** aabb_overlap_box_table: PASSED **");
    end else begin
      $display("** aabb_overlap_box_table: FAILED **");
    end
    $finish;
  end

endmodule
